### src/pidwi_pkg.sv
// Shared constants, register codes and types for the windowed-integral PID core.
package pidwi_pkg;

	// Field widths
	localparam int POS_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int ERR_W     = POS_W + 1;
	localparam int DIFF_W    = ERR_W + 1;
	localparam int DRIVE_W   = 36;
	localparam int CFG_IDX_W = 2;

	// Defaults
	localparam int WINDOW_DEF = 5;

	localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(2);
	localparam logic [GAIN_W-1:0] GAIN_I_RST = GAIN_W'(3);
	localparam logic [GAIN_W-1:0] GAIN_D_RST = GAIN_W'(4);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P = 2'd0,
		REG_GAIN_I = 2'd1,
		REG_GAIN_D = 2'd2
	} cfg_reg_t;

	// Gain register set
	typedef struct packed {
		logic [GAIN_W-1:0] prop;
		logic [GAIN_W-1:0] integ;
		logic [GAIN_W-1:0] deriv;
	} gains_t;

	// Pipeline stage handshake
	typedef struct packed {
		logic valid;
		logic ready;
	} stage_hs_t;

endpackage

### src/pidwi_err.sv
// Error stage: signed error, moving window shift line, running sum and error change.
module pidwi_err
	import pidwi_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF,
	parameter int SUM_W  = ERR_W + $clog2(WINDOW)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [POS_W-1:0]         measured,
	input  logic [POS_W-1:0]         target,
	output stage_hs_t                hs_s2,
	input  logic                     out_ready,
	output logic signed [ERR_W-1:0]  err_s2,
	output logic signed [SUM_W-1:0]  sum_s2,
	output logic signed [DIFF_W-1:0] diff_s2
);

	logic signed [ERR_W-1:0] win_q [WINDOW];
	logic signed [SUM_W-1:0] sum_q;
	logic signed [ERR_W-1:0] prev_q;
	logic                    valid_s2;
	logic                    take;
	logic signed [ERR_W-1:0] err;
	logic signed [SUM_W-1:0] sum_next;

	// Advance when the next stage has room or this one is empty
	assign in_ready = !valid_s2 || out_ready;
	assign take     = in_valid && in_ready;

	assign hs_s2.valid = valid_s2;
	assign hs_s2.ready = in_ready;

	// Error and window sum: add newest, drop oldest
	assign err      = $signed({1'b0, target}) - $signed({1'b0, measured});
	assign sum_next = sum_q + SUM_W'(err) - SUM_W'(win_q[WINDOW-1]);

	// Window state advances once per accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++) begin
				win_q[k] <= '0;
			end
			sum_q  <= '0;
			prev_q <= '0;
		end else if (take) begin
			win_q[0] <= err;
			for (int k = 1; k < WINDOW; k++) begin
				win_q[k] <= win_q[k-1];
			end
			sum_q  <= sum_next;
			prev_q <= err;
		end
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			err_s2  <= err;
			sum_s2  <= sum_next;
			diff_s2 <= DIFF_W'(err) - DIFF_W'(prev_q);
		end
	end

endmodule

### src/pidwi_mac.sv
// Gain stage: three registered products, then sum and saturate to the drive width.
module pidwi_mac
	import pidwi_pkg::*;
#(
	parameter int SUM_W = ERR_W + $clog2(WINDOW_DEF)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gains_t                    gains,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [ERR_W-1:0]   err,
	input  logic signed [SUM_W-1:0]   sum,
	input  logic signed [DIFF_W-1:0]  diff,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [DRIVE_W-1:0]        res
);

	localparam int P_W    = GAIN_W + 1 + ERR_W;
	localparam int I_W    = GAIN_W + 1 + SUM_W;
	localparam int D_W    = GAIN_W + 1 + DIFF_W;
	localparam int MAX_W  = (I_W > D_W) ? I_W : D_W;
	localparam int ACC_W  = MAX_W + 2;

	logic                    valid_s3;
	logic                    take;
	logic signed [P_W-1:0]   prod_p_s3;
	logic signed [I_W-1:0]   prod_i_s3;
	logic signed [D_W-1:0]   prod_d_s3;
	logic signed [ACC_W-1:0] acc;
	logic                    fits;

	assign in_ready = !valid_s3 || res_ready;
	assign take     = in_valid && in_ready;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// Register the three products
	always_ff @(posedge clk) begin
		if (take) begin
			prod_p_s3 <= $signed({1'b0, gains.prop}) * err;
			prod_i_s3 <= $signed({1'b0, gains.integ}) * sum;
			prod_d_s3 <= $signed({1'b0, gains.deriv}) * diff;
		end
	end

	// Sum the terms and clamp to the signed drive range
	assign acc  = ACC_W'(prod_p_s3) + ACC_W'(prod_i_s3) + ACC_W'(prod_d_s3);
	assign fits = (&acc[ACC_W-1:DRIVE_W-1]) || !(|acc[ACC_W-1:DRIVE_W-1]);

	always_comb begin
		if (fits) begin
			res = acc[DRIVE_W-1:0];
		end else if (acc[ACC_W-1]) begin
			res = {1'b1, {(DRIVE_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(DRIVE_W-1){1'b1}}};
		end
	end

	assign res_valid = valid_s3;

endmodule

### src/pidwi_skid.sv
// Output register with a skid entry so the input ready does not depend combinationally on the output ready.
module pidwi_skid
	import pidwi_pkg::*;
#(
	parameter int W = DRIVE_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic         out_valid_q;
	logic         skid_full_q;
	logic [W-1:0] out_data_q;
	logic [W-1:0] skid_data_q;
	logic         push;
	logic         drain;

	assign in_ready  = !skid_full_q;
	assign push      = in_valid && !skid_full_q;
	assign drain     = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Control: refill output from skid first, park a request in skid when stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (drain) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_full_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_full_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= in_data;
			end
		end else if (push) begin
			skid_data_q <= in_data;
		end
	end

endmodule

### src/pid_windowed_integral_core.sv
// Top level of the windowed-integral PID core: gain registers, input register and stage chain.
// Each request carries a measured and a target position; the core forms the error, keeps the
// last WINDOW errors in a shift line with a running sum, and returns
// kp*e + ki*(window sum) + kd*(e - previous e), clamped to 36 signed bits. One request is
// accepted per cycle when the output is taken. The input register loads at the accepting edge;
// the error/window stage, product stage and output register follow in that order, and m_tvalid
// rises when the output register loads the clamped result. Each sum update is a single add and
// subtract on the running total, and the three gain products are computed side by side in one
// stage. Gains must be written through the configuration port only while the core is idle;
// the core itself does not enforce this.
module pid_windowed_integral_core
	import pidwi_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // [15:0] measured_position, [31:16] target_position
	// Result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // [35:0] drive_value, [39:36] zero
	// Configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	localparam int SUM_W = ERR_W + $clog2(WINDOW);

	gains_t                   gains_q;
	logic                     valid_s1;
	logic [POS_W-1:0]         meas_s1;
	logic [POS_W-1:0]         target_s1;
	logic                     rdy_s2;
	stage_hs_t                hs_s2;
	logic                     rdy_s3;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	logic                     res_valid;
	logic                     res_ready;
	logic [DRIVE_W-1:0]       res;
	logic [DRIVE_W-1:0]       drive;

	// Gain registers; writes to unused indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop  <= GAIN_P_RST;
			gains_q.integ <= GAIN_I_RST;
			gains_q.deriv <= GAIN_D_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN_P: gains_q.prop  <= cfg_data;
				REG_GAIN_I: gains_q.integ <= cfg_data;
				REG_GAIN_D: gains_q.deriv <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	assign s_tready = !valid_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			meas_s1   <= s_tdata[POS_W-1:0];
			target_s1 <= s_tdata[2*POS_W-1:POS_W];
		end
	end

	// Error, window and difference
	pidwi_err #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (rdy_s2),
		.measured  (meas_s1),
		.target    (target_s1),
		.hs_s2     (hs_s2),
		.out_ready (rdy_s3),
		.err_s2    (err_s2),
		.sum_s2    (sum_s2),
		.diff_s2   (diff_s2)
	);

	// Gain products and clamp
	pidwi_mac #(
		.SUM_W (SUM_W)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.in_valid  (hs_s2.valid),
		.in_ready  (rdy_s3),
		.err       (err_s2),
		.sum       (sum_s2),
		.diff      (diff_s2),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Result register with skid entry
	pidwi_skid #(
		.W (DRIVE_W)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (drive)
	);

	assign m_tdata = {4'b0000, drive};

endmodule
